### rtl/fpsa_pkg.sv
package fpsa_pkg;

	localparam int ADDR_W         = 32;
	localparam int CMD_W          = 2;
	localparam int FCOUNT_W       = 11;
	localparam int S_TDATA_W      = 32;
	localparam int M_TDATA_W      = 48;
	localparam int PAGE_BYTES_DEF = 4096;
	localparam int MAX_PAGES_DEF  = 1024;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_INIT  = 2'd2
	} cmd_e;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_OOM   = 3'd1,
		ST_RANGE = 3'd2,
		ST_ALIGN = 3'd3,
		ST_FULL  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_FILL
	} state_t;

	localparam logic REG_START = 1'b0;
	localparam logic REG_END   = 1'b1;

	typedef struct packed {
		logic                valid;
		logic [ADDR_W-1:0]   page;
		status_t             status;
		logic [FCOUNT_W-1:0] free_count;
	} result_t;

endpackage

### rtl/free_page_stack_allocator.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser: command; s_tdata: address
// m_*       out  m_tvalid/m_tready  m_tdata: page_address, status, free_count
// cfg_*     in   cfg_we             cfg_index selects region_start or region_end
//
// A word is taken and executed one at a time. Free, an error and an unknown command
// finish in S_EXEC; allocate reads the stack RAM in S_EXEC and finishes in S_READ.
// Initialize pushes the pages in S_FILL, one RAM write per cycle.
// The next word is accepted in the cycle the current one finishes. A result waits
// in the output register; a new result stalls only while that register is full.
// arst_n clears the stack count and the region registers; the stack RAM is not cleared.
module free_page_stack_allocator #(
	parameter int PAGE_BYTES = fpsa_pkg::PAGE_BYTES_DEF,
	parameter int MAX_PAGES  = fpsa_pkg::MAX_PAGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [fpsa_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] address
	input  logic [fpsa_pkg::CMD_W-1:0]     s_tuser,  // [1:0] command
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [31:0] page_address, [34:32] status, [45:35] free_count, [47:46] zero
	output logic [fpsa_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [fpsa_pkg::ADDR_W-1:0]    cfg_data
);

	fpsa_pkg::result_t res, out_q;
	logic out_valid_q, out_free;

	assign out_free = !out_valid_q || m_tready;

	fpsa_ctrl #(
		.PAGE_BYTES(PAGE_BYTES),
		.MAX_PAGES (MAX_PAGES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (s_tuser),
		.in_addr  (s_tdata[fpsa_pkg::ADDR_W-1:0]),
		.out_free (out_free),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q.free_count, out_q.status, out_q.page};

`ifndef SYNTHESIS
	a_oom_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == fpsa_pkg::ST_OOM |->
		out_q.page == '0 && out_q.free_count == '0)
		else $error("out of memory result with nonzero page or count");

	a_page_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.page != '0 |-> out_q.status == fpsa_pkg::ST_OK)
		else $error("page address given with an error status");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> out_free)
		else $error("result produced while output register is held");
`endif

endmodule

### rtl/fpsa_ram.sv
module fpsa_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/fpsa_ctrl.sv
module fpsa_ctrl #(
	parameter int PAGE_BYTES = fpsa_pkg::PAGE_BYTES_DEF,
	parameter int MAX_PAGES  = fpsa_pkg::MAX_PAGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [fpsa_pkg::ADDR_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [fpsa_pkg::CMD_W-1:0]  in_cmd,
	input  logic [fpsa_pkg::ADDR_W-1:0] in_addr,
	input  logic                        out_free,
	output fpsa_pkg::result_t           res
);

	localparam int ADDR_W = fpsa_pkg::ADDR_W;
	localparam int PG_SH  = $clog2(PAGE_BYTES);
	localparam int PN_W   = ADDR_W - PG_SH;
	localparam int CNT_W  = $clog2(MAX_PAGES + 1);
	localparam int IDX_W  = $clog2(MAX_PAGES);

	fpsa_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt_dec;
	logic [ADDR_W-1:0] start_q, end_q;
	logic [fpsa_pkg::CMD_W-1:0] cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W:0] walk_q, walk_d;
	logic accept, fin, full, walk_more;
	logic ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	logic [PN_W-1:0] ram_wdata, ram_rdata;
	fpsa_pkg::status_t free_st;

	fpsa_ram #(
		.WIDTH(PN_W),
		.DEPTH(MAX_PAGES)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign cnt_dec   = cnt_q - 1'b1;
	assign full      = (cnt_q == CNT_W'(MAX_PAGES));
	assign walk_more = (walk_q < {1'b0, end_q}) && !full;
	assign accept    = in_valid && in_ready;

	always_comb begin
		if (addr_q >= end_q || addr_q < start_q) begin
			free_st = fpsa_pkg::ST_RANGE;
		end else if (addr_q[PG_SH-1:0] != '0) begin
			free_st = fpsa_pkg::ST_ALIGN;
		end else if (full) begin
			free_st = fpsa_pkg::ST_FULL;
		end else begin
			free_st = fpsa_pkg::ST_OK;
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		walk_d     = walk_q;
		fin        = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = cnt_q[IDX_W-1:0];
		ram_wdata  = addr_q[ADDR_W-1:PG_SH];
		ram_re     = 1'b0;
		ram_raddr  = cnt_dec[IDX_W-1:0];
		res.page   = '0;
		res.status = fpsa_pkg::ST_OK;
		case (state_q)
			fpsa_pkg::S_IDLE: begin
			end
			fpsa_pkg::S_EXEC: begin
				case (cmd_q)
					fpsa_pkg::CMD_ALLOC: begin
						if (cnt_q == '0) begin
							res.status = fpsa_pkg::ST_OOM;
							fin        = out_free;
						end else begin
							ram_re  = 1'b1;
							state_d = fpsa_pkg::S_READ;
						end
					end
					fpsa_pkg::CMD_FREE: begin
						res.status = free_st;
						fin        = out_free;
						if (out_free && free_st == fpsa_pkg::ST_OK) begin
							ram_we = 1'b1;
							cnt_d  = cnt_q + 1'b1;
						end
					end
					fpsa_pkg::CMD_INIT: begin
						if (start_q[PG_SH-1:0] != '0) begin
							res.status = fpsa_pkg::ST_ALIGN;
							fin        = out_free;
						end else begin
							cnt_d   = '0;
							walk_d  = {1'b0, start_q};
							state_d = fpsa_pkg::S_FILL;
						end
					end
					default: begin
						fin = out_free;
					end
				endcase
			end
			fpsa_pkg::S_READ: begin
				// Read data stays on the RAM output until the next read.
				res.page = {ram_rdata, PG_SH'(0)};
				fin      = out_free;
				if (out_free) begin
					cnt_d = cnt_dec;
				end
			end
			fpsa_pkg::S_FILL: begin
				if (walk_more) begin
					ram_we    = 1'b1;
					ram_wdata = walk_q[ADDR_W-1:PG_SH];
					cnt_d     = cnt_q + 1'b1;
					walk_d    = walk_q + (ADDR_W + 1)'(PAGE_BYTES);
				end else begin
					fin = out_free;
				end
			end
			default: begin
				state_d = fpsa_pkg::S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = fpsa_pkg::S_IDLE;
		end
		if (accept) begin
			state_d = fpsa_pkg::S_EXEC;
		end
		res.valid      = fin;
		res.free_count = fpsa_pkg::FCOUNT_W'(cnt_d);
	end

	assign in_ready = (state_q == fpsa_pkg::S_IDLE) || fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpsa_pkg::S_IDLE;
			cnt_q   <= '0;
			start_q <= '0;
			end_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cfg_we) begin
				if (cfg_index == fpsa_pkg::REG_START) begin
					start_q <= cfg_data;
				end else begin
					end_q <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		walk_q <= walk_d;
		if (accept) begin
			cmd_q  <= in_cmd;
			addr_q <= in_addr;
		end
	end

endmodule
